@@ src/oadc_pkg.sv @@
// Shared types, constants and calibration tables for the obstacle-avoid drive controller.
// No dependencies; the ctrl, dpath and top files use this package by scoped names.
`timescale 1ns / 1ps
package oadc_pkg;

	localparam int TABLE_LEN_DEF = 19;
	localparam int TAB_CAP       = 32;
	localparam int TAB_IDX_W     = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_SET_DIST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DUTY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TURN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_TURN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_WRAP  = 3'd4;

	// reset values
	localparam logic [7:0]  RST_SET_DIST   = 8'd20;
	localparam logic [6:0]  RST_DRIVE_DUTY = 7'd90;
	localparam logic [15:0] RST_RIGHT_TURN = 16'd150;
	localparam logic [15:0] RST_LEFT_TURN  = 16'd160;
	localparam logic [7:0]  RST_TICK_WRAP  = 8'd10;
	localparam logic [6:0]  RST_DISTANCE   = 7'd10;
	localparam logic [6:0]  DUTY_MAX       = 7'd100;
	localparam logic [6:0]  DIST_MAX       = 7'd127;
	localparam logic [8:0]  DIST_BASE      = 9'd10;
	localparam logic [8:0]  DIST_STEP      = 9'd5;

	typedef enum logic [2:0] {
		MODE_CHECK       = 3'd0,
		MODE_FORWARD     = 3'd1,
		MODE_AWAIT_SIDE  = 3'd2,
		MODE_PIVOT_RIGHT = 3'd3,
		MODE_PIVOT_LEFT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CH_FRONT = 2'd0,
		CH_RIGHT = 2'd1,
		CH_LEFT  = 2'd2
	} chan_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_WALK   = 2'd1,
		S_COMMIT = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic walk_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_done;
		logic out_free;
	} dp_stat_t;

	localparam logic [7:0] CAL_FRONT [TAB_CAP] = '{
		8'd127, 8'd91, 8'd71, 8'd59, 8'd49, 8'd44, 8'd39, 8'd36,
		8'd33,  8'd30, 8'd28, 8'd27, 8'd24, 8'd23, 8'd22, 8'd21,
		8'd21,  8'd19, 8'd20, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
		8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
	};

	localparam logic [7:0] CAL_RIGHT [TAB_CAP] = '{
		8'd123, 8'd86, 8'd67, 8'd54, 8'd46, 8'd42, 8'd39, 8'd38,
		8'd37,  8'd38, 8'd34, 8'd34, 8'd36, 8'd39, 8'd41, 8'd37,
		8'd39,  8'd42, 8'd42, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
		8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
	};

	localparam logic [7:0] CAL_LEFT [TAB_CAP] = '{
		8'd126, 8'd89, 8'd69, 8'd55, 8'd46, 8'd41, 8'd36, 8'd32,
		8'd30,  8'd27, 8'd24, 8'd23, 8'd21, 8'd19, 8'd19, 8'd18,
		8'd17,  8'd16, 8'd15, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
		8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
	};

	function automatic logic [7:0] cal_entry(input chan_t side,
			input logic [TAB_IDX_W-1:0] idx);
		logic [7:0] e;
		case (side)
			CH_RIGHT: e = CAL_RIGHT[idx];
			CH_LEFT:  e = CAL_LEFT[idx];
			default:  e = CAL_FRONT[idx];
		endcase
		return e;
	endfunction

endpackage

@@ src/oadc_in_if.sv @@
// Input channel: sensor sample or timer tick request, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
interface oadc_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] sample;

	modport source(output valid, action, sample, input ready);
	modport sink(input valid, action, sample, output ready);
endinterface

@@ src/oadc_out_if.sv @@
// Output channel: drive status result, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
interface oadc_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] left_duty_pct;
	logic [6:0] right_duty_pct;
	logic [1:0] next_channel;
	logic [6:0] distance_cm;
	logic [2:0] mode;
	logic       rotating;

	modport source(output valid, left_duty_pct, right_duty_pct, next_channel,
		distance_cm, mode, rotating, input ready);
	modport sink(input valid, left_duty_pct, right_duty_pct, next_channel,
		distance_cm, mode, rotating, output ready);
endinterface

@@ src/oadc_ctrl.sv @@
// Sequencer for the drive controller: accept, table walk, commit.
// Depends on oadc_pkg.
`timescale 1ns / 1ps
module oadc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  oadc_pkg::dp_stat_t   stat,
	output oadc_pkg::ctrl_cmd_t  cmd
);

	oadc_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oadc_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			oadc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = oadc_pkg::S_WALK;
				end
			end
			oadc_pkg::S_WALK: begin
				if (!stat.need_walk) begin
					state_n = oadc_pkg::S_COMMIT;
				end else begin
					cmd.walk_step = 1'b1;
					if (stat.walk_done)
						state_n = oadc_pkg::S_COMMIT;
				end
			end
			oadc_pkg::S_COMMIT: begin
				// wait for the output register to free up
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_n    = oadc_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = oadc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ src/oadc_dpath.sv @@
// Datapath: config registers, drive state, calibration walk and output register.
// Depends on oadc_pkg, oadc_out_if.
`timescale 1ns / 1ps
module oadc_dpath #(
	parameter int TABLE_LEN = oadc_pkg::TABLE_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [oadc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [oadc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_action,
	input  logic [7:0]                           in_sample,
	input  oadc_pkg::ctrl_cmd_t                  cmd,
	output oadc_pkg::dp_stat_t                   stat,
	oadc_out_if.source                           result
);

	localparam int KW = $clog2(TABLE_LEN + 1);
	localparam int IW = oadc_pkg::TAB_IDX_W;

	// config
	logic [7:0]  set_dist_q;
	logic [6:0]  duty_cfg_q;
	logic [15:0] rturn_q;
	logic [15:0] lturn_q;
	logic [7:0]  wrap_q;

	// drive state
	oadc_pkg::mode_t mode_q, mode_n;
	logic        prefer_left_q, prefer_n;
	logic [7:0]  tick_q, tick_n;
	logic [15:0] hund_q, hund_n;
	logic [6:0]  last_dist_q, last_n;

	// request and walk
	logic          action_q;
	logic [7:0]    sample_q;
	logic [KW-1:0] k_q;

	// output register
	logic        out_valid_q;
	logic [6:0]  out_ld_q, out_rd_q, out_dist_q;
	logic [1:0]  out_ch_q;
	logic [2:0]  out_mode_q;
	logic        out_rot_q;

	logic            pivot;
	oadc_pkg::chan_t side;
	logic [IW-1:0]   idx;
	logic [7:0]      entry;
	logic            hit;
	logic [8:0]      dist_w;
	logic [6:0]      dist_cm;
	logic            dist_clear;
	logic [6:0]      duty;
	logic [15:0]     pivot_len, side_len, hund_inc;
	logic [6:0]      ld_n, rd_n;
	logic [1:0]      ch_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_dist_q <= oadc_pkg::RST_SET_DIST;
			duty_cfg_q <= oadc_pkg::RST_DRIVE_DUTY;
			rturn_q    <= oadc_pkg::RST_RIGHT_TURN;
			lturn_q    <= oadc_pkg::RST_LEFT_TURN;
			wrap_q     <= oadc_pkg::RST_TICK_WRAP;
		end else if (cfg_wen) begin
			case (cfg_index)
				oadc_pkg::REG_SET_DIST:   set_dist_q <= cfg_data[7:0];
				oadc_pkg::REG_DRIVE_DUTY: duty_cfg_q <= cfg_data[6:0];
				oadc_pkg::REG_RIGHT_TURN: rturn_q    <= cfg_data;
				oadc_pkg::REG_LEFT_TURN:  lturn_q    <= cfg_data;
				oadc_pkg::REG_TICK_WRAP:  wrap_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign pivot = (mode_q == oadc_pkg::MODE_PIVOT_RIGHT) ||
		(mode_q == oadc_pkg::MODE_PIVOT_LEFT);

	// calibration walk, one entry per cycle
	always_comb begin
		if (mode_q != oadc_pkg::MODE_AWAIT_SIDE)
			side = oadc_pkg::CH_FRONT;
		else if (prefer_left_q)
			side = oadc_pkg::CH_LEFT;
		else
			side = oadc_pkg::CH_RIGHT;
	end
	assign idx   = IW'(k_q);
	assign entry = oadc_pkg::cal_entry(side, idx);
	assign hit   = sample_q >= entry;

	assign stat.need_walk = !action_q && !pivot;
	assign stat.walk_done = hit || (k_q == KW'(TABLE_LEN - 1));
	assign stat.out_free  = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q <= 1'b0;
			sample_q <= '0;
			k_q      <= '0;
		end else if (cmd.capture) begin
			action_q <= in_action;
			sample_q <= in_sample;
			k_q      <= '0;
		end else if (cmd.walk_step && !hit) begin
			// miss on the last entry leaves k at TABLE_LEN
			k_q <= k_q + KW'(1);
		end
	end

	// distance = 10 + 5k, clipped at 127
	assign dist_w     = oadc_pkg::DIST_BASE + 9'(k_q) * oadc_pkg::DIST_STEP;
	assign dist_cm    = (dist_w > 9'(oadc_pkg::DIST_MAX)) ? oadc_pkg::DIST_MAX : dist_w[6:0];
	assign dist_clear = {1'b0, dist_cm} > set_dist_q;

	assign duty      = (duty_cfg_q > oadc_pkg::DUTY_MAX) ? oadc_pkg::DUTY_MAX : duty_cfg_q;
	assign pivot_len = (mode_q == oadc_pkg::MODE_PIVOT_RIGHT) ? rturn_q : lturn_q;
	assign side_len  = prefer_left_q ? lturn_q : rturn_q;
	assign hund_inc  = (tick_q < wrap_q) ? hund_q : hund_q + 16'd1;

	always_comb begin
		mode_n   = mode_q;
		prefer_n = prefer_left_q;
		tick_n   = tick_q;
		hund_n   = hund_q;
		last_n   = last_dist_q;
		if (action_q) begin
			if (pivot) begin
				tick_n = (tick_q < wrap_q) ? tick_q + 8'd1 : 8'd0;
				if (hund_inc >= pivot_len) begin
					hund_n = '0;
					mode_n = oadc_pkg::MODE_CHECK;
				end else begin
					hund_n = hund_inc;
				end
			end
		end else if (!pivot) begin
			last_n = dist_cm;
			if (mode_q == oadc_pkg::MODE_AWAIT_SIDE) begin
				prefer_n = !prefer_left_q;
				if (dist_clear) begin
					hund_n = '0;
					if (side_len == 16'd0)
						mode_n = oadc_pkg::MODE_CHECK;
					else if (prefer_left_q)
						mode_n = oadc_pkg::MODE_PIVOT_LEFT;
					else
						mode_n = oadc_pkg::MODE_PIVOT_RIGHT;
				end else begin
					mode_n = oadc_pkg::MODE_CHECK;
				end
			end else if (dist_clear) begin
				mode_n = oadc_pkg::MODE_FORWARD;
			end else if (mode_q == oadc_pkg::MODE_FORWARD) begin
				mode_n = oadc_pkg::MODE_CHECK;
			end else begin
				mode_n = oadc_pkg::MODE_AWAIT_SIDE;
			end
		end
	end

	always_comb begin
		ld_n = '0;
		rd_n = '0;
		ch_n = oadc_pkg::CH_FRONT;
		case (mode_n)
			oadc_pkg::MODE_FORWARD: begin
				ld_n = duty;
				rd_n = duty;
			end
			oadc_pkg::MODE_AWAIT_SIDE: begin
				ch_n = prefer_n ? oadc_pkg::CH_LEFT : oadc_pkg::CH_RIGHT;
			end
			oadc_pkg::MODE_PIVOT_RIGHT: ld_n = duty;
			oadc_pkg::MODE_PIVOT_LEFT:  rd_n = duty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= oadc_pkg::MODE_CHECK;
			prefer_left_q <= 1'b0;
			tick_q        <= '0;
			hund_q        <= '0;
			last_dist_q   <= oadc_pkg::RST_DISTANCE;
		end else if (cmd.commit) begin
			mode_q        <= mode_n;
			prefer_left_q <= prefer_n;
			tick_q        <= tick_n;
			hund_q        <= hund_n;
			last_dist_q   <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_ld_q   <= ld_n;
			out_rd_q   <= rd_n;
			out_ch_q   <= ch_n;
			out_dist_q <= last_n;
			out_mode_q <= mode_n;
			out_rot_q  <= (mode_n == oadc_pkg::MODE_PIVOT_RIGHT) ||
				(mode_n == oadc_pkg::MODE_PIVOT_LEFT);
		end
	end

	assign result.valid          = out_valid_q;
	assign result.left_duty_pct  = out_ld_q;
	assign result.right_duty_pct = out_rd_q;
	assign result.next_channel   = out_ch_q;
	assign result.distance_cm    = out_dist_q;
	assign result.mode           = out_mode_q;
	assign result.rotating       = out_rot_q;

endmodule

@@ src/obstacle_avoid_drive_controller.sv @@
// Top level of the obstacle-avoid drive controller: sequencer plus datapath.
// Depends on oadc_pkg, oadc_in_if, oadc_out_if, oadc_ctrl, oadc_dpath.
`timescale 1ns / 1ps
// Each request on the sensor channel is either a range sample (action 0) from the
// channel named by the last result's next_channel, or a timer tick (action 1), and
// yields exactly one status result. A sample is turned into a distance by walking
// the front, right or left calibration table one entry per cycle until the sample
// is not below the entry (10 cm + 5 cm per entry passed, TABLE_LEN entries at most).
// The block handles one request at a time: a request is accepted only while the
// sequencer is idle. An accepted sample that needs the walk steps through the table
// in the walk state; ticks and samples taken during a pivot pass through that state
// without a step. The commit state then updates the drive state and loads the output
// register once it is free, and the sequencer returns to idle, so no new request is
// taken before the last one is committed. A finished result sits in an
// output register, so the next request is accepted while it waits to be taken;
// only a second result backs up behind an untaken one. Config writes (set
// distance, drive duty, right and left pivot length, tick wrap) are taken on any
// cycle with cfg_wen high and should be done while the block is idle.
module obstacle_avoid_drive_controller #(
	parameter int TABLE_LEN = oadc_pkg::TABLE_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	oadc_in_if.sink                         sensor,
	oadc_out_if.source                      result,
	input  logic                            cfg_wen,
	input  logic [oadc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oadc_pkg::CFG_DATA_W-1:0] cfg_data
);

	oadc_pkg::ctrl_cmd_t cmd;
	oadc_pkg::dp_stat_t  stat;

	// sequencer: idle -> walk table -> commit when output slot free
	oadc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sensor.valid),
		.in_ready (sensor.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, calibration lookup, mode update and output register
	oadc_dpath #(
		.TABLE_LEN (TABLE_LEN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (sensor.action),
		.in_sample (sensor.sample),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

`ifndef SYNTH
	// one request in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sensor.valid && sensor.ready |=> !sensor.ready)
		else $error("request accepted while another is in flight");

	// rotating flag agrees with the pivot modes
	a_rot_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.rotating ==
		((result.mode == oadc_pkg::MODE_PIVOT_RIGHT) ||
		(result.mode == oadc_pkg::MODE_PIVOT_LEFT))))
		else $error("rotating flag disagrees with mode");

	// a pivot drives one wheel only
	a_pivot_one_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.rotating |->
		(result.left_duty_pct == 7'd0) || (result.right_duty_pct == 7'd0))
		else $error("both wheels driven during a pivot");

	// side channel is only requested while awaiting a side sample
	a_side_chan: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.next_channel != oadc_pkg::CH_FRONT) |->
		(result.mode == oadc_pkg::MODE_AWAIT_SIDE))
		else $error("side channel requested outside await mode");
`endif

endmodule
